// ===== rtl/mft_pkg.sv =====
package mft_pkg;

  typedef enum logic [1:0] {
    STATUS_OFFLINE = 2'd0,
    STATUS_STOPPED = 2'd1,
    STATUS_RUNNING = 2'd2
  } status_t;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic LAYOUT_CURRENT = 1'b0;
  localparam logic LAYOUT_MIT     = 1'b1;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_DATA_W = 17;

  localparam logic [REG_IDX_W-1:0] REG_CONTROL_MODE       = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POSITION_ENABLE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENCODER_RESOLUTION = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFLINE_LIMIT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STALL_THRESHOLD    = 3'd4;

  localparam logic [16:0] RESOLUTION_RESET = 17'h10000;
  localparam logic [9:0]  OFFLINE_RESET    = 10'd50;
  localparam logic [11:0] STALL_RESET      = 12'd50;

  typedef struct packed {
    logic        control_mode;
    logic        position_enable;
    logic [16:0] encoder_resolution;
    logic [9:0]  offline_limit;
    logic [11:0] stall_threshold;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [63:0] frame_data;
    logic [31:0] stamp;
  } item_t;

  typedef struct packed {
    logic signed [16:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] effort;
    logic [15:0]        temps;
    logic [7:0]         ident_fault;
    logic               ident_write;
  } decode_t;

  typedef struct packed {
    logic               accepted;
    logic signed [16:0] angle;
    logic signed [15:0] speed;
    logic signed [15:0] effort;
    logic signed [7:0]  temp_first;
    logic signed [7:0]  temp_second;
    logic [3:0]         motor_ident;
    logic [3:0]         motor_fault_state;
    logic signed [31:0] position;
    status_t            status;
    logic               enable_request;
  } result_t;

endpackage

// ===== rtl/mft_item_if.sv =====
interface mft_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] frame_data;
  logic [31:0] stamp;

  modport source (output valid, output op, output frame_data, output stamp, input ready);
  modport sink (input valid, input op, input frame_data, input stamp, output ready);
endinterface

// ===== rtl/mft_result_if.sv =====
interface mft_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [16:0] angle;
  logic signed [15:0] speed;
  logic signed [15:0] effort;
  logic signed [7:0]  temp_first;
  logic signed [7:0]  temp_second;
  logic [3:0]         motor_ident;
  logic [3:0]         motor_fault_state;
  logic signed [31:0] position;
  logic [1:0]         status;
  logic               enable_request;

  modport source (
    output valid, output accepted, output angle, output speed, output effort,
    output temp_first, output temp_second, output motor_ident,
    output motor_fault_state, output position, output status,
    output enable_request, input ready
  );
  modport sink (
    input valid, input accepted, input angle, input speed, input effort,
    input temp_first, input temp_second, input motor_ident,
    input motor_fault_state, input position, input status,
    input enable_request, output ready
  );
endinterface

// ===== rtl/mft_decode.sv =====
module mft_decode (
  input  logic [63:0]     frame_data,
  input  logic            control_mode,
  output mft_pkg::decode_t dec
);
  import mft_pkg::*;

  logic [7:0] b [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = frame_data[63 - 8*k -: 8];
    end
  end

  always_comb begin
    if (control_mode == LAYOUT_MIT) begin
      dec.ident_fault = b[0];
      dec.ident_write = 1'b1;
      dec.angle       = {1'b0, b[1], b[2]};
      dec.speed       = {4'b0000, b[3], b[4][7:4]};
      dec.effort      = {4'b0000, b[4][3:0], b[5]};
      dec.temps       = {b[6], b[7]};
    end else begin
      dec.ident_fault = 8'h00;
      dec.ident_write = 1'b0;
      dec.angle       = {b[0][7], b[0], b[1]};
      dec.speed       = {b[2], b[3]};
      dec.effort      = {b[4], b[5]};
      dec.temps       = {b[6], 8'h00};
    end
  end
endmodule

// ===== rtl/mft_core.sv =====
module mft_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mft_pkg::item_t   item,
  input  mft_pkg::decode_t dec,
  input  mft_pkg::cfg_t    cfg,
  output mft_pkg::result_t res
);
  import mft_pkg::*;

  logic [31:0]        last_stamp, last_stamp_next;
  logic signed [16:0] angle_now, angle_now_next;
  logic signed [16:0] prev_angle, prev_angle_next;
  logic signed [15:0] speed_now, speed_now_next;
  logic signed [15:0] effort_now, effort_now_next;
  logic [15:0]        temps_now, temps_now_next;
  logic [7:0]         ident_fault, ident_fault_next;
  logic [31:0]        position_now, position_now_next;
  status_t            link_status, link_status_next;

  logic               frame_ok;
  logic signed [18:0] diff, half_pos, half_neg, res_s, corr;
  logic [31:0]        elapsed;
  logic [16:0]        spd_ext, mag;

  assign frame_ok = (item.op == OP_FRAME) && (item.stamp >= last_stamp);

  // unwrap: difference of the new and the previous angle, folded by one revolution
  assign diff     = {{2{dec.angle[16]}}, dec.angle} - {{2{prev_angle[16]}}, prev_angle};
  assign half_pos = {3'b000, cfg.encoder_resolution[16:1]};
  assign half_neg = -half_pos;
  assign res_s    = {2'b00, cfg.encoder_resolution};

  always_comb begin
    if (diff > half_pos) begin
      corr = diff - res_s;
    end else if (diff < half_neg) begin
      corr = diff + res_s;
    end else begin
      corr = diff;
    end
  end

  assign elapsed = item.stamp - last_stamp;
  assign spd_ext = {speed_now[15], speed_now};
  assign mag     = spd_ext[16] ? (17'd0 - spd_ext) : spd_ext;

  always_comb begin
    last_stamp_next   = last_stamp;
    angle_now_next    = angle_now;
    prev_angle_next   = prev_angle;
    speed_now_next    = speed_now;
    effort_now_next   = effort_now;
    temps_now_next    = temps_now;
    ident_fault_next  = ident_fault;
    position_now_next = position_now;
    link_status_next  = link_status;
    if (frame_ok) begin
      last_stamp_next = item.stamp;
      angle_now_next  = dec.angle;
      speed_now_next  = dec.speed;
      effort_now_next = dec.effort;
      temps_now_next  = dec.temps;
      if (dec.ident_write) begin
        ident_fault_next = dec.ident_fault;
      end
      priority if (!cfg.position_enable || link_status == STATUS_OFFLINE) begin
        position_now_next = 32'd0;
      end else if (position_now == 32'd0 && prev_angle == 17'sd0) begin
        prev_angle_next   = dec.angle;
        position_now_next = 32'd0;
      end else begin
        prev_angle_next   = dec.angle;
        position_now_next = position_now + {{13{corr[18]}}, corr};
      end
    end else if (item.op == OP_TICK) begin
      priority if (elapsed > {22'd0, cfg.offline_limit}) begin
        link_status_next = STATUS_OFFLINE;
      end else if (mag < {5'd0, cfg.stall_threshold}) begin
        link_status_next = STATUS_STOPPED;
      end else begin
        link_status_next = STATUS_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp   <= '0;
      angle_now    <= '0;
      prev_angle   <= '0;
      speed_now    <= '0;
      effort_now   <= '0;
      temps_now    <= '0;
      ident_fault  <= '0;
      position_now <= '0;
      link_status  <= STATUS_OFFLINE;
    end else if (step) begin
      last_stamp   <= last_stamp_next;
      angle_now    <= angle_now_next;
      prev_angle   <= prev_angle_next;
      speed_now    <= speed_now_next;
      effort_now   <= effort_now_next;
      temps_now    <= temps_now_next;
      ident_fault  <= ident_fault_next;
      position_now <= position_now_next;
      link_status  <= link_status_next;
    end
  end

  always_comb begin
    res.accepted          = frame_ok;
    res.angle             = angle_now_next;
    res.speed             = speed_now_next;
    res.effort            = effort_now_next;
    res.temp_first        = temps_now_next[15:8];
    res.temp_second       = temps_now_next[7:0];
    res.motor_ident       = ident_fault_next[3:0];
    res.motor_fault_state = ident_fault_next[7:4];
    res.position          = position_now_next;
    res.status            = link_status_next;
    res.enable_request    = (item.op == OP_TICK) && (cfg.control_mode == LAYOUT_MIT);
  end
endmodule

// ===== rtl/mft_outq.sv =====
module mft_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mft_pkg::result_t push_data,
  output logic             space,
  mft_result_if.source     results
);
  import mft_pkg::*;

  result_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;
  result_t    head;

  assign pop   = results.valid && results.ready;
  assign space = (count != 2'd2);
  assign head  = entry[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign results.valid             = (count != 2'd0);
  assign results.accepted          = head.accepted;
  assign results.angle             = head.angle;
  assign results.speed             = head.speed;
  assign results.effort            = head.effort;
  assign results.temp_first        = head.temp_first;
  assign results.temp_second       = head.temp_second;
  assign results.motor_ident       = head.motor_ident;
  assign results.motor_fault_state = head.motor_fault_state;
  assign results.position          = head.position;
  assign results.status            = head.status;
  assign results.enable_request    = head.enable_request;
endmodule

// ===== rtl/motor_feedback_tracker.sv =====
// Channel   Dir  Beat                                   Handshake
// --------  ---  -------------------------------------  -----------
// items     in   op, frame_data[63:0], stamp[31:0]      valid/ready
// results   out  decoded frame, position, status, req   valid/ready
// wr_*      in   register index[2:0], data[16:0]        wr_en only
//
// One beat in, one beat out. A beat is registered on entry, processed by the
// decode and unwrap logic while it waits in that register, and the result is
// written to a two-entry output queue when the queue has a slot; results are
// offered from the queue head. One beat per cycle is sustained while results
// drain; the two queue slots let the input side keep going while a result
// waits for its taker.
// Reset (rst, synchronous) clears the tracker state to zero with the link
// offline, and loads the register defaults.
module motor_feedback_tracker (
  input  logic                             clk,
  input  logic                             rst,
  mft_item_if.sink                         items,
  mft_result_if.source                     results,
  input  logic                             wr_en,
  input  logic [mft_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [mft_pkg::REG_DATA_W-1:0]   wr_data
);
  import mft_pkg::*;

  cfg_t    cfg;
  logic    hold_valid;
  item_t   hold_item;
  logic    load;
  logic    advance;
  logic    q_space;
  decode_t dec;
  result_t res;

  // configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_mode       <= LAYOUT_CURRENT;
      cfg.position_enable    <= 1'b0;
      cfg.encoder_resolution <= RESOLUTION_RESET;
      cfg.offline_limit      <= OFFLINE_RESET;
      cfg.stall_threshold    <= STALL_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CONTROL_MODE:       cfg.control_mode       <= wr_data[0];
        REG_POSITION_ENABLE:    cfg.position_enable    <= wr_data[0];
        REG_ENCODER_RESOLUTION: cfg.encoder_resolution <= wr_data[16:0];
        REG_OFFLINE_LIMIT:      cfg.offline_limit      <= wr_data[9:0];
        REG_STALL_THRESHOLD:    cfg.stall_threshold    <= wr_data[11:0];
        default: ;
      endcase
    end
  end

  // input register: advance into the tracker whenever the queue has a slot,
  // and take a fresh beat in the same cycle
  assign advance     = hold_valid && q_space;
  assign items.ready = !hold_valid || q_space;
  assign load        = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      hold_item.op         <= items.op;
      hold_item.frame_data <= items.frame_data;
      hold_item.stamp      <= items.stamp;
    end
  end

  mft_decode u_decode (
    .frame_data   (hold_item.frame_data),
    .control_mode (cfg.control_mode),
    .dec          (dec)
  );

  // state update and result assembly for the beat in the input register
  mft_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (hold_item),
    .dec  (dec),
    .cfg  (cfg),
    .res  (res)
  );

  mft_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (res),
    .space     (q_space),
    .results   (results)
  );

  // a waiting beat with a full queue must still be there, unchanged
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !q_space |=> hold_valid && $stable(hold_item))
    else $error("input register lost a stalled beat");

  // an accepted frame never raises the enable request
  a_req_tick_only: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.accepted |-> !results.enable_request)
    else $error("enable request on an accepted frame");

  // with accumulation off an accepted frame leaves position at zero
  a_pos_disabled: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.accepted && !cfg.position_enable |-> results.position == 32'sd0)
    else $error("position moved while disabled");

  // the input is never refused while the result queue is empty
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> items.ready)
    else $error("input refused with an empty result queue");
endmodule

// ===== tb/sv/motor_feedback_tracker_test.sv =====
`timescale 1ns / 100ps

module motor_feedback_tracker_test;
  import mft_pkg::*;

  // Out-of-list register index: the block must ignore writes to it.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Margin after the last readout before touching registers.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  // Cycles without any beat on either channel before the run is abandoned.
  localparam int QUIET_LIMIT   = 2000;
  // Cap on mismatch lines so a broken block cannot flood the log.
  localparam int REPORT_CAP    = 60;

  logic clk;
  logic rst = 1'b1;

  mft_item_if   item_ch ();
  mft_result_if result_ch ();

  // Driven copies of the block inputs, all known from time zero.
  logic                 feed_valid = 1'b0;
  item_t                feed_beat  = '0;
  logic                 take_ok    = 1'b0;
  logic                 wr_en      = 1'b0;
  logic [REG_IDX_W-1:0] wr_index   = '0;
  logic [REG_DATA_W-1:0] wr_data   = '0;

  assign item_ch.valid      = feed_valid;
  assign item_ch.op         = feed_beat.op;
  assign item_ch.frame_data = feed_beat.frame_data;
  assign item_ch.stamp      = feed_beat.stamp;
  assign result_ch.ready    = take_ok;

  motor_feedback_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .items    (item_ch),
    .results  (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tracker shadow: our own copy of the registers and of the stored feedback.
  // ---------------------------------------------------------------------------
  cfg_t shadow_cfg = '{
    control_mode:       LAYOUT_CURRENT,
    position_enable:    1'b0,
    encoder_resolution: RESOLUTION_RESET,
    offline_limit:      OFFLINE_RESET,
    stall_threshold:    STALL_RESET
  };

  logic [31:0]        last_seen_stamp = '0;
  logic signed [16:0] stored_angle    = '0;
  logic signed [16:0] anchor_angle    = '0;  // angle the next unwrap step starts from
  logic signed [15:0] stored_speed    = '0;
  logic signed [15:0] stored_effort   = '0;
  logic [15:0]        stored_temps    = '0;  // first temperature in the high byte
  logic [7:0]         stored_id_fault = '0;  // fault nibble high, ident nibble low
  logic [31:0]        turn_count      = '0;  // multi-turn position, wraps at 32 bits
  status_t            link_now        = STATUS_OFFLINE;

  result_t pending_readouts[$];

  int send_idle_pct  = 0;
  int take_stall_pct = 0;
  int mismatch_count = 0;
  int readout_index  = 0;

  // Work out the readout one beat produces and advance the shadow state.
  function automatic result_t track_feedback(item_t beat);
    result_t     r;
    logic [7:0]  fb [8];
    longint      delta;
    longint      span;
    longint      half;
    logic [31:0] elapsed;
    int          mag;
    int          k;
    r = '0;
    if (beat.op == OP_FRAME) begin
      // Late frames are dropped without touching anything.
      if (beat.stamp >= last_seen_stamp) begin
        for (k = 0; k < 8; k++) fb[k] = beat.frame_data[63 - 8 * k -: 8];
        if (shadow_cfg.control_mode == LAYOUT_CURRENT) begin
          // Signed 16-bit fields; ident and fault are left as they were.
          stored_angle  = {fb[0][7], fb[0], fb[1]};
          stored_speed  = {fb[2], fb[3]};
          stored_effort = {fb[4], fb[5]};
          stored_temps  = {fb[6], 8'h00};
        end else begin
          // MIT layout: unsigned angle, 12-bit speed and torque packed across byte 4.
          stored_id_fault = fb[0];
          stored_angle    = {1'b0, fb[1], fb[2]};
          stored_speed    = {4'h0, fb[3], fb[4][7:4]};
          stored_effort   = {4'h0, fb[4][3:0], fb[5]};
          stored_temps    = {fb[6], fb[7]};
        end
        if (!shadow_cfg.position_enable || link_now == STATUS_OFFLINE) begin
          // Hold zero and leave the anchor alone.
          turn_count = '0;
        end else if (turn_count == 0 && anchor_angle == 0) begin
          // First sample: latch the anchor, position stays at zero.
          anchor_angle = stored_angle;
        end else begin
          delta = longint'(stored_angle) - longint'(anchor_angle);
          span  = longint'(shadow_cfg.encoder_resolution);
          half  = span / 2;
          if (delta > half) delta -= span;
          else if (-delta > half) delta += span;
          anchor_angle = stored_angle;
          turn_count   = turn_count + delta[31:0];
        end
        last_seen_stamp = beat.stamp;
        r.accepted      = 1'b1;
      end
    end else begin
      r.enable_request = (shadow_cfg.control_mode == LAYOUT_MIT);
      // Elapsed time is taken modulo 2^32, so a stamp behind the last frame is huge.
      elapsed = beat.stamp - last_seen_stamp;
      if (elapsed > shadow_cfg.offline_limit) begin
        link_now = STATUS_OFFLINE;
      end else begin
        mag = (stored_speed < 0) ? -int'(stored_speed) : int'(stored_speed);
        link_now = (mag < int'(shadow_cfg.stall_threshold)) ? STATUS_STOPPED : STATUS_RUNNING;
      end
    end
    r.angle             = stored_angle;
    r.speed             = stored_speed;
    r.effort            = stored_effort;
    r.temp_first        = stored_temps[15:8];
    r.temp_second       = stored_temps[7:0];
    r.motor_ident       = stored_id_fault[3:0];
    r.motor_fault_state = stored_id_fault[7:4];
    r.position          = turn_count;
    r.status            = link_now;
    return r;
  endfunction

  function automatic logic [63:0] current_frame(logic [15:0] ang, logic [15:0] spd,
                                                logic [15:0] eff, logic [7:0] tmp,
                                                logic [7:0] spare);
    return {ang, spd, eff, tmp, spare};
  endfunction

  function automatic logic [63:0] mit_frame(logic [7:0] id_fault, logic [15:0] ang,
                                            logic [11:0] spd, logic [11:0] eff,
                                            logic [7:0] t_first, logic [7:0] t_second);
    return {id_fault, ang, spd, eff, t_first, t_second};
  endfunction

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then record the readout it should give.
  task automatic send_item(logic op, logic [63:0] data, logic [31:0] stamp);
    item_t beat;
    beat.op         = op;
    beat.frame_data = data;
    beat.stamp      = stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      feed_valid <= 1'b0;
      @(posedge clk);
    end
    feed_valid <= 1'b1;
    feed_beat  <= beat;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_readouts.push_back(track_feedback(beat));
  endtask

  task automatic send_frame(logic [63:0] data, logic [31:0] stamp);
    send_item(OP_FRAME, data, stamp);
  endtask

  // Tick payload is ignored by the block; fill it with noise anyway.
  task automatic send_tick(logic [31:0] stamp);
    send_item(OP_TICK, {$urandom, $urandom}, stamp);
  endtask

  // ---------------------------------------------------------------------------
  // Register side
  // ---------------------------------------------------------------------------

  task automatic put_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
  endtask

  // Drain the block, then write every register in one burst of back-to-back writes.
  task automatic load_settings(cfg_t c);
    feed_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    put_register(REG_CONTROL_MODE, REG_DATA_W'(c.control_mode));
    put_register(REG_POSITION_ENABLE, REG_DATA_W'(c.position_enable));
    put_register(REG_ENCODER_RESOLUTION, c.encoder_resolution);
    put_register(REG_OFFLINE_LIMIT, REG_DATA_W'(c.offline_limit));
    put_register(REG_STALL_THRESHOLD, REG_DATA_W'(c.stall_threshold));
    put_register(REG_UNUSED, REG_DATA_W'($urandom));
    wr_en <= 1'b0;
    shadow_cfg = c;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, then compare each beat with the oldest readout.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string note);
    if (mismatch_count < REPORT_CAP) $display("[%0t] readout %0d: %s", $realtime, readout_index, note);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        want = pending_readouts.pop_front();
        check_field("accepted", 32'(result_ch.accepted), 32'(want.accepted));
        check_field("angle", 32'(result_ch.angle), 32'(want.angle));
        check_field("speed", 32'(result_ch.speed), 32'(want.speed));
        check_field("effort", 32'(result_ch.effort), 32'(want.effort));
        check_field("temp_first", 32'(result_ch.temp_first), 32'(want.temp_first));
        check_field("temp_second", 32'(result_ch.temp_second), 32'(want.temp_second));
        check_field("motor_ident", 32'(result_ch.motor_ident), 32'(want.motor_ident));
        check_field("motor_fault_state", 32'(result_ch.motor_fault_state),
                    32'(want.motor_fault_state));
        check_field("position", result_ch.position, want.position);
        check_field("status", 32'(result_ch.status), 32'(want.status));
        check_field("enable_request", 32'(result_ch.enable_request),
                    32'(want.enable_request));
      end
      readout_index++;
    end
    take_ok <= ($urandom_range(99) >= take_stall_pct);
  end

  // Abandon the run if neither channel moves a beat for too long.
  always @(posedge clk) begin : quiet_watch
    int quiet_cycles;
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("motor_feedback_tracker verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset defaults, current layout: all-ones frame, then sign extremes at an equal stamp.
  task automatic test_current_decode();
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, last_seen_stamp);
    send_frame(current_frame(16'h8000, 16'h7FFF, 16'h8000, 8'h7F, 8'hA5), last_seen_stamp);
  endtask

  // A frame behind the last accepted stamp must change nothing.
  task automatic test_late_frame();
    send_frame({$urandom, $urandom}, last_seen_stamp + 32'd100);
    send_frame({$urandom, $urandom}, last_seen_stamp - 32'd1);
    send_tick(last_seen_stamp + 32'd10);
  endtask

  // MIT layout: ident and fault nibbles, 12-bit fields, enable request on a tick.
  task automatic test_mit_decode();
    cfg_t c;
    c = shadow_cfg;
    c.control_mode = LAYOUT_MIT;
    load_settings(c);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, last_seen_stamp + 32'd1);
    send_frame(mit_frame(8'h5A, 16'hFFFF, 12'hFFF, 12'h800, 8'h80, 8'h7F), last_seen_stamp);
    send_tick(last_seen_stamp);
  endtask

  // First-sample latch, then forward and backward wraps across the half-turn mark.
  task automatic test_position_unwrap();
    cfg_t c;
    c = shadow_cfg;
    c.control_mode       = LAYOUT_MIT;
    c.position_enable    = 1'b1;
    c.encoder_resolution = 17'h10000;
    load_settings(c);
    send_tick(last_seen_stamp);
    send_frame(mit_frame(8'h00, 16'd0, 12'd0, 12'd0, 8'd0, 8'd0), last_seen_stamp + 32'd1);
    send_frame(mit_frame(8'h3C, 16'd1000, 12'd7, 12'd9, 8'd20, 8'd21), last_seen_stamp + 32'd1);
    send_frame(mit_frame(8'h3C, 16'd65000, 12'd7, 12'd9, 8'd20, 8'd21), last_seen_stamp + 32'd1);
    send_frame(mit_frame(8'h3C, 16'd200, 12'd7, 12'd9, 8'd20, 8'd21), last_seen_stamp + 32'd1);
    send_frame(mit_frame(8'h3C, 16'd33000, 12'd7, 12'd9, 8'd20, 8'd21), last_seen_stamp + 32'd1);
  endtask

  // A resolution of zero has a half of zero: no correction however far the angle jumps.
  task automatic test_zero_resolution();
    cfg_t c;
    c = shadow_cfg;
    c.encoder_resolution = '0;
    load_settings(c);
    send_frame(mit_frame(8'h11, 16'd60000, 12'd1, 12'd2, 8'd3, 8'd4), last_seen_stamp);
    send_frame(mit_frame(8'h11, 16'd10, 12'd1, 12'd2, 8'd3, 8'd4), last_seen_stamp);
  endtask

  // Offline link or disabled tracking forces position to zero and freezes the anchor.
  task automatic test_offline_and_disabled();
    cfg_t c;
    send_tick(last_seen_stamp + 32'(shadow_cfg.offline_limit) + 32'd1);
    send_frame(mit_frame(8'h22, 16'd40000, 12'd5, 12'd6, 8'd7, 8'd8), last_seen_stamp + 32'd2);
    send_tick(last_seen_stamp + 32'(shadow_cfg.offline_limit));
    send_frame(mit_frame(8'h22, 16'd40100, 12'd5, 12'd6, 8'd7, 8'd8), last_seen_stamp + 32'd2);
    c = shadow_cfg;
    c.position_enable = 1'b0;
    load_settings(c);
    send_frame(mit_frame(8'h22, 16'd40200, 12'd5, 12'd6, 8'd7, 8'd8), last_seen_stamp);
  endtask

  // Status edges: elapsed equal to the limit, most negative speed, zero threshold,
  // and a tick stamp behind the last frame.
  task automatic test_tick_status();
    cfg_t c;
    c = shadow_cfg;
    c.control_mode    = LAYOUT_CURRENT;
    c.position_enable = 1'b1;
    c.offline_limit   = 10'd1023;
    c.stall_threshold = 12'd4095;
    load_settings(c);
    // Current layout must leave the MIT ident and fault nibbles untouched.
    send_frame(current_frame(16'h0123, 16'h8000, 16'h7FFF, 8'h80, 8'hFF), last_seen_stamp);
    send_tick(last_seen_stamp + 32'd1023);
    c.offline_limit   = '0;
    c.stall_threshold = '0;
    load_settings(c);
    send_tick(last_seen_stamp);
    send_tick(last_seen_stamp - 32'd1);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // Mostly well-formed traffic: frames with a smoothly walking angle and ticks inside
  // the offline window, salted with late frames, time jumps and stray ticks.
  task automatic test_random_traffic(int count, cfg_t c, int idle_pct, int stall_pct);
    logic [15:0] angle_walk;
    logic [15:0] spd;
    logic [15:0] step;
    logic [31:0] stamp;
    int          pick;
    int          back;
    int          n;
    load_settings(c);
    send_idle_pct  = idle_pct;
    take_stall_pct = stall_pct;
    angle_walk = stored_angle[15:0];
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        step = ($urandom_range(9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, 1200)) - 16'd600;
        angle_walk += step;
        spd = $urandom_range(1) ? 16'($urandom_range(0, 400)) - 16'd200 : 16'($urandom);
        stamp = last_seen_stamp + 32'($urandom_range(0, 6));
        if (shadow_cfg.control_mode == LAYOUT_CURRENT)
          send_frame(current_frame(angle_walk, spd, 16'($urandom), 8'($urandom), 8'($urandom)),
                     stamp);
        else
          send_frame(mit_frame(8'($urandom), angle_walk, spd[11:0], 12'($urandom),
                               8'($urandom), 8'($urandom)), stamp);
      end else if (pick < 78) begin
        // Mostly inside the window, now and then just past it.
        send_tick(last_seen_stamp + 32'($urandom_range(0, shadow_cfg.offline_limit
                                                         + shadow_cfg.offline_limit / 4 + 4)));
      end else if (pick < 86) begin
        if (last_seen_stamp == 0) begin
          stamp = '0;
        end else begin
          back  = (last_seen_stamp > 1000) ? 1000 : int'(last_seen_stamp);
          stamp = last_seen_stamp - 32'($urandom_range(1, back));
        end
        send_frame({$urandom, $urandom}, stamp);
      end else if (pick < 94) begin
        send_frame({$urandom, $urandom}, last_seen_stamp + 32'($urandom_range(0, 100000)));
        angle_walk = stored_angle[15:0];
      end else begin
        send_tick($urandom);
      end
    end
  endtask

  // Frames at the top of the stamp range; run last since they lock out lower stamps.
  task automatic test_stamp_ceiling();
    cfg_t c;
    int   n;
    c.control_mode       = logic'($urandom_range(1));
    c.position_enable    = 1'b1;
    c.encoder_resolution = 17'h10000;
    c.offline_limit      = 10'($urandom);
    c.stall_threshold    = 12'($urandom);
    load_settings(c);
    send_frame({$urandom, $urandom}, 32'hFFFF_FFFF);
    for (n = 0; n < 6; n++) begin
      if ($urandom_range(2) == 0) send_tick(32'hFFFF_FFFF);
      else send_frame({$urandom, $urandom}, 32'hFFFF_FFFF);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_current_decode();
    test_late_frame();
    test_mit_decode();
    test_position_unwrap();
    test_zero_resolution();
    test_offline_and_disabled();
    test_tick_status();

    // No idling, default-like window and threshold.
    c = '{LAYOUT_CURRENT, 1'b1, 17'h10000, 10'd50, 12'd50};
    test_random_traffic(240, c, 0, 0);
    // Sender mostly idle, widest window and highest threshold.
    c = '{LAYOUT_MIT, 1'b1, 17'h10000, 10'd1023, 12'd4095};
    test_random_traffic(240, c, 88, 0);
    // Receiver mostly stalled, tightest window, zero threshold, unit resolution.
    c = '{LAYOUT_CURRENT, 1'b1, 17'd1, 10'd0, 12'd0};
    test_random_traffic(230, c, 0, 88);
    // Both sides idling, random settings including the largest resolution code.
    c.control_mode       = logic'($urandom_range(1));
    c.position_enable    = ($urandom_range(3) != 0);
    c.encoder_resolution = 17'h1FFFF;
    c.offline_limit      = 10'($urandom_range(0, 1023));
    c.stall_threshold    = 12'($urandom);
    test_random_traffic(120, c, 36, 36);
    c.control_mode       = ~c.control_mode;
    c.position_enable    = 1'b1;
    c.encoder_resolution = 17'($urandom_range(0, 65536));
    c.offline_limit      = 10'($urandom_range(0, 1023));
    c.stall_threshold    = 12'($urandom);
    test_random_traffic(120, c, 36, 36);

    test_stamp_ceiling();

    // Let the last readouts drain, then idle so that any stray result beat still shows.
    feed_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("motor_feedback_tracker verification clean");
    end else begin
      $display("motor_feedback_tracker verification failed");
    end
    $finish;
  end

endmodule
